// ===== design/tkst_pkg.sv =====
// Shared types and action codes for the top-k sorted score table.
package tkst_pkg;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_DELETE = 3'd1;
	localparam logic [2:0] ACT_QUERY  = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] score;
		logic [15:0] words;
	} tkst_entry_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  entry_total;
		logic [31:0] found_tag;
		logic [31:0] found_score;
		logic [15:0] found_words;
	} tkst_result_t;

endpackage

// ===== design/tkst_table_mem.sv =====
// Entry memory of the score table: one write port, one registered read port.
module tkst_table_mem
	import tkst_pkg::*;
#(
	parameter int DEPTH = 7,
	parameter int AW    = 3
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  tkst_entry_t       wr_data,
	input  logic [AW-1:0]     rd_addr,
	output tkst_entry_t       rd_data
);

	tkst_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/tkst_ctrl.sv =====
// Sequencer that walks the entry memory for insert, delete, query and read.
module tkst_ctrl
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = 7,
	parameter int AW          = 3,
	parameter int CW          = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        action,
	input  logic [31:0]       player_tag,
	input  logic [31:0]       score,
	input  logic [15:0]       word_count,
	input  logic [2:0]        position,
	input  logic              out_free,
	output logic              done,
	output tkst_result_t      result,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output tkst_entry_t       wr_data,
	output logic [AW-1:0]     rd_addr,
	input  tkst_entry_t       rd_data
);

	localparam int WW = (CW > 3) ? CW : 3;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_PUT  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] held_q, held_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [AW-1:0] addr_q, addr_d;
	logic          found_q, found_d;
	logic          chk_q, chk_d;
	logic [2:0]    op_q, op_d;
	tkst_entry_t   req_q, req_d;
	tkst_result_t  res_q, res_d;

	logic [CW-1:0] idx_dec, idx_dec2, idx_inc, held_dec, held_inc;
	logic [WW-1:0] pos_w, held_w;
	logic          is_full, match, found_now;

	assign idx_dec   = idx_q - ONE_C;
	assign idx_dec2  = idx_q - CW'(2);
	assign idx_inc   = idx_q + ONE_C;
	assign held_dec  = held_q - ONE_C;
	assign held_inc  = held_q + ONE_C;
	assign pos_w     = WW'(position);
	assign held_w    = WW'(held_q);
	assign is_full   = (held_q == DEPTH_C);
	assign match     = (rd_data == req_q);
	assign found_now = found_q | match;

	assign in_stall = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE);
	assign rd_addr  = addr_q;

	always_comb begin
		result             = res_q;
		result.entry_total = held_w[2:0];
	end

	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		idx_d   = idx_q;
		addr_d  = addr_q;
		found_d = found_q;
		chk_d   = chk_q;
		op_d    = op_q;
		req_d   = req_q;
		res_d   = res_q;
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = req_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d    = action;
					req_d   = '{tag: player_tag, score: score, words: word_count};
					res_d   = '0;
					found_d = 1'b0;
					chk_d   = 1'b0;
					state_d = S_DONE;
					case (action)
						ACT_INSERT: begin
							if (is_full) begin
								// Check first whether the new score beats the lowest entry.
								idx_d   = DEPTH_C - ONE_C;
								addr_d  = LAST_A;
								chk_d   = 1'b1;
								state_d = S_READ;
							end else if (held_q == '0) begin
								idx_d   = '0;
								state_d = S_PUT;
							end else begin
								idx_d   = held_q;
								addr_d  = held_dec[AW-1:0];
								state_d = S_READ;
							end
						end
						ACT_DELETE: begin
							if (held_q != '0) begin
								idx_d   = '0;
								addr_d  = '0;
								state_d = S_READ;
							end
						end
						ACT_QUERY: begin
							if (is_full) begin
								addr_d  = LAST_A;
								state_d = S_READ;
							end else begin
								res_d.accepted = 1'b1;
							end
						end
						ACT_CLEAR: begin
							held_d         = '0;
							res_d.accepted = 1'b1;
						end
						ACT_READ: begin
							if (pos_w < held_w) begin
								addr_d  = pos_w[AW-1:0];
								state_d = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_DONE;
				case (op_q)
					ACT_INSERT: begin
						if (chk_q) begin
							chk_d = 1'b0;
							if (rd_data.score < req_q.score) begin
								// The lowest entry is dropped; walk up from the last rank.
								if (idx_q == '0) begin
									state_d = S_PUT;
								end else begin
									addr_d  = idx_dec[AW-1:0];
									state_d = S_READ;
								end
							end else begin
								res_d.accepted = 1'b1;
							end
						end else if (rd_data.score < req_q.score) begin
							// Lower entry moves down one rank.
							wr_en   = 1'b1;
							wr_data = rd_data;
							idx_d   = idx_dec;
							if (idx_q == ONE_C) begin
								state_d = S_PUT;
							end else begin
								addr_d  = idx_dec2[AW-1:0];
								state_d = S_READ;
							end
						end else begin
							state_d = S_PUT;
						end
					end
					ACT_DELETE: begin
						// Entries after the match move up one rank.
						if (found_q) begin
							wr_en   = 1'b1;
							wr_addr = idx_dec[AW-1:0];
							wr_data = rd_data;
						end
						found_d = found_now;
						if (idx_inc < held_q) begin
							idx_d   = idx_inc;
							addr_d  = idx_inc[AW-1:0];
							state_d = S_READ;
						end else begin
							if (found_now) begin
								held_d = held_dec;
							end
							res_d.accepted = found_now;
						end
					end
					ACT_QUERY: begin
						res_d.accepted = (req_q.score >= rd_data.score);
					end
					ACT_READ: begin
						res_d.accepted    = 1'b1;
						res_d.found_tag   = rd_data.tag;
						res_d.found_score = rd_data.score;
						res_d.found_words = rd_data.words;
					end
					default: begin
					end
				endcase
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = req_q;
				if (!is_full) begin
					held_d = held_inc;
				end
				res_d.accepted = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		addr_q  <= addr_d;
		found_q <= found_d;
		chk_q   <= chk_d;
		op_q    <= op_d;
		req_q   <= req_d;
		res_q   <= res_d;
	end

endmodule

// ===== design/top_k_sorted_score_table.sv =====
// Top-k sorted score table: request and result channels around the table sequencer.
//
// A request on the input channel (in_valid, in_stall) carries an action: insert, delete,
// high-score query, clear or read by rank. Each request yields exactly one result on the
// output channel (out_valid, out_stall), in request order.
// The entries live in a memory with a registered read port, kept in descending score
// order; insert and delete move entries one rank per memory access, each access being
// a read state and then an evaluate state. Clear, an unknown action, a read past the
// count and a query on a table not full need no memory access; a read within the count
// and a query on a full table read a single entry; delete reads every entry held; insert
// reads upward from the lowest entry and stops where the new entry belongs.
// One request is worked on at a time; in_stall stays high until its result is handed
// to the output register, after which the next request can be taken.
// The output register holds a finished result while out_stall is high, so the next
// request can already be accepted and worked on meanwhile.
// Reset empties the table (entry count zero) and clears both channels; entry contents
// are not cleared, since only ranks below the count are ever read.
module top_k_sorted_score_table
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] player_tag,
	input  logic [31:0] score,
	input  logic [15:0] word_count,
	input  logic [2:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [2:0]  entry_total,
	output logic [31:0] found_tag,
	output logic [31:0] found_score,
	output logic [15:0] found_words
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic          out_valid_q;
	tkst_result_t  out_q;
	logic          out_free;
	logic          done;
	tkst_result_t  result;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	tkst_entry_t   wr_data;
	logic [AW-1:0] rd_addr;
	tkst_entry_t   rd_data;

	assign out_free = !out_valid_q || !out_stall;

	tkst_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.player_tag (player_tag),
		.score      (score),
		.word_count (word_count),
		.position   (position),
		.out_free   (out_free),
		.done       (done),
		.result     (result),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	tkst_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = out_q.accepted;
	assign entry_total = out_q.entry_total;
	assign found_tag   = out_q.found_tag;
	assign found_score = out_q.found_score;
	assign found_words = out_q.found_words;

endmodule

// ===== tb/tkst_checker.sv =====
`timescale 1ns / 1ps
// Checker for the score table: predicts each result from accepted requests and compares them.
module tkst_checker
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] player_tag,
	input  logic [31:0] score,
	input  logic [15:0] word_count,
	input  logic [2:0]  position,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        accepted,
	input  logic [2:0]  entry_total,
	input  logic [31:0] found_tag,
	input  logic [31:0] found_score,
	input  logic [15:0] found_words,
	output int          fail_count,
	output int          pending
);

	tkst_entry_t  rank_table [TABLE_DEPTH];
	int           ranks_held;
	tkst_result_t results_due [$];
	int           mismatches;

	task automatic report_mismatch(string msg);
		$display("%0t ns: score table mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one request to the predicted table and returns the result it should produce.
	function automatic tkst_result_t apply_request(logic [2:0] act, tkst_entry_t ent,
			logic [2:0] pos);
		tkst_result_t res;
		int at;
		int last;
		res = '0;
		case (act)
			ACT_INSERT: begin
				at = 0;
				// Ties go after the entries already held.
				while (at < ranks_held && rank_table[at].score >= ent.score)
					at++;
				if (at < TABLE_DEPTH) begin
					last = (ranks_held < TABLE_DEPTH) ? ranks_held : TABLE_DEPTH - 1;
					for (int i = last; i > at; i--)
						rank_table[i] = rank_table[i - 1];
					rank_table[at] = ent;
					if (ranks_held < TABLE_DEPTH)
						ranks_held++;
				end
				res.accepted = 1'b1;
			end
			ACT_DELETE: begin
				at = 0;
				while (at < ranks_held && rank_table[at] != ent)
					at++;
				if (at < ranks_held) begin
					for (int i = at; i + 1 < ranks_held; i++)
						rank_table[i] = rank_table[i + 1];
					ranks_held--;
					res.accepted = 1'b1;
				end
			end
			ACT_QUERY: begin
				res.accepted = (ranks_held < TABLE_DEPTH) ||
					(ent.score >= rank_table[TABLE_DEPTH - 1].score);
			end
			ACT_CLEAR: begin
				ranks_held = 0;
				res.accepted = 1'b1;
			end
			ACT_READ: begin
				if (pos < ranks_held) begin
					res.accepted = 1'b1;
					res.found_tag = rank_table[pos].tag;
					res.found_score = rank_table[pos].score;
					res.found_words = rank_table[pos].words;
				end
			end
			default: begin
			end
		endcase
		res.entry_total = 3'(ranks_held);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		tkst_result_t seen;
		tkst_result_t due;
		if (!arst_n) begin
			ranks_held = 0;
			foreach (rank_table[i])
				rank_table[i] = '0;
			results_due.delete();
			mismatches = 0;
		end else begin
			// The result leaving now always belongs to an earlier request, so it goes first.
			if (out_valid && !out_stall) begin
				seen = '{accepted, entry_total, found_tag, found_score, found_words};
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no request outstanding", seen));
				end else begin
					due = results_due.pop_front();
					if (seen.accepted !== due.accepted)
						report_mismatch($sformatf("accepted %b, expected %b",
							seen.accepted, due.accepted));
					if (seen.entry_total !== due.entry_total)
						report_mismatch($sformatf("entry_total %0d, expected %0d",
							seen.entry_total, due.entry_total));
					if (seen.found_tag !== due.found_tag)
						report_mismatch($sformatf("found_tag %h, expected %h",
							seen.found_tag, due.found_tag));
					if (seen.found_score !== due.found_score)
						report_mismatch($sformatf("found_score %h, expected %h",
							seen.found_score, due.found_score));
					if (seen.found_words !== due.found_words)
						report_mismatch($sformatf("found_words %h, expected %h",
							seen.found_words, due.found_words));
				end
			end
			if (in_valid && !in_stall)
				results_due.push_back(apply_request(action,
					'{player_tag, score, word_count}, position));
		end
		fail_count <= mismatches;
		pending <= results_due.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the score table: clock, reset, request stimulus, result stalls and verdict.
module tb;
	import tkst_pkg::*;

	localparam int TABLE_DEPTH = 7;
	// Action codes the block does not define; they must leave the table alone.
	localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
	localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [31:0] player_tag;
	logic [31:0] score;
	logic [15:0] word_count;
	logic [2:0]  position;
	logic        out_valid;
	logic        out_stall;
	logic        accepted;
	logic [2:0]  entry_total;
	logic [31:0] found_tag;
	logic [31:0] found_score;
	logic [15:0] found_words;
	int          fail_count;
	int          pending;
	logic        quiet_link;

	top_k_sorted_score_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .player_tag(player_tag), .score(score),
		.word_count(word_count), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .entry_total(entry_total),
		.found_tag(found_tag), .found_score(found_score), .found_words(found_words)
	);

	tkst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) score_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .player_tag(player_tag), .score(score),
		.word_count(word_count), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .entry_total(entry_total),
		.found_tag(found_tag), .found_score(found_score), .found_words(found_words),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(3_000_000);
		$display("FAILURE");
		$finish;
	end

	// Mostly no gap or a short one, now and then a long one.
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Small scores make ties common; the extremes and full-range values cover every bit.
	function automatic logic [31:0] pick_score();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 32'($urandom_range(0, 15));
		if (roll < 65)
			return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic send_request(logic [2:0] act, logic [31:0] tag, logic [31:0] sc,
			logic [15:0] wc, logic [2:0] pos);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		player_tag <= tag;
		score <= sc;
		word_count <= wc;
		position <= pos;
		do @(posedge clk); while (in_stall);
		gap = quiet_link ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : result_stalls
		int run_len;
		int stall_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = $urandom_range(1, 12);
			repeat (run_len) @(posedge clk);
			stall_len = idle_cycles();
			if (stall_len > 0 && !quiet_link) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		tkst_entry_t recent_inserts [$];
		tkst_entry_t ent;
		logic [2:0]  act;
		int          roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_INSERT;
		player_tag = '0;
		score = '0;
		word_count = '0;
		position = '0;
		quiet_link = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: read past the count, query, delete with nothing to match.
		send_request(ACT_READ, 32'h0, 32'h0, 16'h0, 3'd0);
		send_request(ACT_QUERY, 32'h0, 32'h0, 16'h0, 3'd0);
		send_request(ACT_DELETE, 32'h1, 32'h1, 16'h1, 3'd0);
		// Fill with extremes and ties; equal scores land behind the earlier entries.
		send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd7);
		send_request(ACT_INSERT, 32'h0, 32'h0, 16'h0, 3'd0);
		send_request(ACT_INSERT, 32'h1, 32'd100, 16'd5, 3'd0);
		send_request(ACT_INSERT, 32'h2, 32'd100, 16'd6, 3'd0);
		send_request(ACT_INSERT, 32'h3, 32'd50, 16'd7, 3'd0);
		send_request(ACT_INSERT, 32'h4, 32'd200, 16'd8, 3'd0);
		send_request(ACT_INSERT, 32'h5, 32'd100, 16'd9, 3'd0);
		// Full table: a higher score pushes out the lowest, a tie or a lower one is dropped.
		send_request(ACT_INSERT, 32'h6, 32'd10, 16'd1, 3'd0);
		send_request(ACT_INSERT, 32'h7, 32'd10, 16'd2, 3'd0);
		send_request(ACT_INSERT, 32'h8, 32'd3, 16'd3, 3'd0);
		send_request(ACT_QUERY, 32'h0, 32'd9, 16'h0, 3'd0);
		send_request(ACT_QUERY, 32'h0, 32'd10, 16'h0, 3'd0);
		send_request(ACT_QUERY, 32'h0, 32'hFFFF_FFFF, 16'h0, 3'd0);
		send_request(ACT_READ, 32'h0, 32'h0, 16'h0, 3'd0);
		send_request(ACT_READ, 32'h0, 32'h0, 16'h0, 3'd6);
		send_request(ACT_READ, 32'h0, 32'h0, 16'h0, 3'd7);
		// A match needs all three fields; the second delete differs only in words.
		send_request(ACT_DELETE, 32'h2, 32'd100, 16'd6, 3'd0);
		send_request(ACT_DELETE, 32'h2, 32'd100, 16'd7, 3'd0);
		send_request(ACT_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
		send_request(ACT_READ, 32'h0, 32'h0, 16'h0, 3'd4);
		for (int code = ACT_RESERVED_LO; code <= ACT_RESERVED_HI; code++)
			send_request(3'(code), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'(code));
		send_request(ACT_CLEAR, 32'h0, 32'h0, 16'h0, 3'd0);
		send_request(ACT_READ, 32'h0, 32'h0, 16'h0, 3'd0);

		for (int n = 0; n < 1100; n++) begin
			quiet_link = (n % 200) < 40;
			if (n % 250 == 125)
				drain_results();
			ent.tag = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
			ent.score = pick_score();
			ent.words = ($urandom_range(0, 1) == 0) ?
				16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				act = ACT_INSERT;
				recent_inserts.push_back(ent);
				if (recent_inserts.size() > 12)
					void'(recent_inserts.pop_front());
			end else if (roll < 60) begin
				act = ACT_DELETE;
				// Most deletes aim at an entry that was inserted lately.
				if (recent_inserts.size() > 0 && $urandom_range(0, 3) != 0)
					ent = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
			end else if (roll < 73) begin
				act = ACT_QUERY;
			end else if (roll < 93) begin
				act = ACT_READ;
			end else if (roll < 96) begin
				act = ACT_CLEAR;
			end else begin
				act = 3'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
			end
			send_request(act, ent.tag, ent.score, ent.words, 3'($urandom_range(0, 7)));
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
design/tkst_pkg.sv
design/tkst_table_mem.sv
design/tkst_ctrl.sv
design/top_k_sorted_score_table.sv
tb/tkst_checker.sv
tb/tb.sv
